[design/phs_pkg.sv]
package phs_pkg;

    localparam int NUM_BINS   = 1024;
    localparam int BIN_AW     = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int COUNT_W    = 16;
    localparam int PC_W       = 32;
    localparam int SCALE_W    = 17;
    localparam int BINS_W     = 11;
    localparam int IDX_W      = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int PROD_W     = (PC_W - 1) + SCALE_W;

    localparam logic [SCALE_W-1:0] SCALE_MAX     = SCALE_W'(65536);
    localparam logic [BINS_W-1:0]  BINS_RESET    = BINS_W'(1024);

    localparam logic [1:0] REQ_SAMPLE = 2'd0;
    localparam logic [1:0] REQ_READ   = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_PC     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE       = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_BINS_IN_USE = CFG_IDX_W'(2);

    typedef struct packed {
        logic [1:0]       req_type;
        logic [PC_W-1:0]  pc_value;
        logic [IDX_W-1:0] read_bin;
    } in_item_t;

    typedef struct packed {
        logic               counted;
        logic [IDX_W-1:0]   bin_index;
        logic [COUNT_W-1:0] bin_count;
    } out_item_t;

    // bin mapping result handed from the mapper to the sequencer
    typedef struct packed {
        logic              hit;
        logic [BIN_AW-1:0] addr;
        logic [IDX_W-1:0]  index;
    } map_result_t;

endpackage

[design/pc_sample_histogram.sv]
// A sample item passes S_MUL, S_LOOK and S_UPD, a read item S_RDOUT, a clear item
//   the S_CLR sweep, each then S_DONE to the output register; one item is in work
//   at a time, set by the read-modify-write through the single bin memory.
// Reset: synchronous active-low; afterwards a clearing pass over all NUM_BINS (1024) entries
//   zeroes the bin memory while s_ready stays low; config writes are taken meanwhile.
module pc_sample_histogram (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [phs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [phs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  phs_pkg::in_item_t              s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output phs_pkg::out_item_t             m_data
);
    import phs_pkg::*;

    typedef enum logic [2:0] {
        S_INIT,   // post-reset clearing pass
        S_IDLE,   // waiting for an item
        S_MUL,    // mapper multiplying
        S_LOOK,   // bin known, memory read issued
        S_UPD,    // read data back, increment and write
        S_RDOUT,  // read item data back
        S_CLR,    // clear item sweep
        S_DONE    // result waits for the output register
    } state_t;

    // configuration registers
    logic [PC_W-1:0]    base_pc_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic [BINS_W-1:0]  bins_reg;

    // sequencer
    state_t            state_reg, state_next;
    logic [BIN_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic              hit_reg, hit_next;
    logic              rd_ok_reg, rd_ok_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    out_item_t         res_reg, res_next;
    logic              m_valid_reg, m_valid_next;
    out_item_t         m_data_reg, m_data_next;

    // memory port
    logic               ram_we;
    logic [BIN_AW-1:0]  ram_waddr;
    logic [COUNT_W-1:0] ram_wdata;
    logic [BIN_AW-1:0]  ram_raddr;
    logic [COUNT_W-1:0] ram_rdata;

    map_result_t        map_res;
    logic               in_accept;
    logic [PC_W-1:0]    rb_ext;
    logic [COUNT_W-1:0] count_inc;
    logic               clr_last;

    assign in_accept = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign rb_ext    = PC_W'(s_data.read_bin);
    assign count_inc = ram_rdata + COUNT_W'(1);
    assign clr_last  = (clr_cnt_reg == BIN_AW'(NUM_BINS - 1));

    // config: out-of-range scale writes are dropped, unknown indexes ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_pc_reg <= '0;
            scale_reg   <= '0;
            bins_reg    <= BINS_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_BASE_PC: base_pc_reg <= cfg_wdata[PC_W-1:0];
                CFG_SCALE: begin
                    if (cfg_wdata[SCALE_W-1:0] <= SCALE_MAX) begin
                        scale_reg <= cfg_wdata[SCALE_W-1:0];
                    end
                end
                CFG_BINS_IN_USE: bins_reg <= cfg_wdata[BINS_W-1:0];
                default: ;
            endcase
        end
    end

    phs_bin_map u_map (
        .aclk        (aclk),
        .load        (in_accept),
        .pc_value    (s_data.pc_value),
        .base_pc     (base_pc_reg),
        .scale       (scale_reg),
        .bins_in_use (bins_reg),
        .result      (map_res)
    );

    phs_bin_ram #(
        .DEPTH (NUM_BINS),
        .WIDTH (COUNT_W),
        .AW    (BIN_AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        hit_next     = hit_reg;
        rd_ok_next   = rd_ok_reg;
        idx_next     = idx_reg;
        res_next     = res_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;
        s_ready      = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = clr_cnt_reg;
        ram_wdata    = '0;
        ram_raddr    = map_res.addr;

        // output register drains independently of the sequencer
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_INIT: begin
                ram_we       = 1'b1;
                clr_cnt_next = clr_cnt_reg + BIN_AW'(1);
                if (clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready   = 1'b1;
                ram_raddr = rb_ext[BIN_AW-1:0];
                if (s_valid) begin
                    case (s_data.req_type)
                        REQ_SAMPLE: state_next = S_MUL;
                        REQ_READ: begin
                            rd_ok_next = (rb_ext < PC_W'(NUM_BINS));
                            idx_next   = s_data.read_bin;
                            state_next = S_RDOUT;
                        end
                        REQ_CLEAR: begin
                            clr_cnt_next = '0;
                            state_next   = S_CLR;
                        end
                        default: begin
                            // unknown request: no state change, zero result
                            res_next   = '0;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_MUL: state_next = S_LOOK;
            S_LOOK: begin
                hit_next   = map_res.hit;
                state_next = S_UPD;
            end
            S_UPD: begin
                ram_waddr = map_res.addr;
                ram_wdata = count_inc;
                if (hit_reg) begin
                    ram_we             = 1'b1;
                    res_next.counted   = 1'b1;
                    res_next.bin_index = map_res.index;
                    res_next.bin_count = count_inc;
                end else begin
                    res_next = '0;
                end
                state_next = S_DONE;
            end
            S_RDOUT: begin
                res_next.counted   = 1'b0;
                res_next.bin_index = idx_reg;
                res_next.bin_count = rd_ok_reg ? ram_rdata : '0;
                state_next         = S_DONE;
            end
            S_CLR: begin
                ram_we       = 1'b1;
                clr_cnt_next = clr_cnt_reg + BIN_AW'(1);
                if (clr_last) begin
                    res_next   = '0;
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
        end
        hit_reg    <= hit_next;
        rd_ok_reg  <= rd_ok_next;
        idx_reg    <= idx_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    // memory is written only by the sweeps and the increment step
    a_we_states: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == S_UPD || state_reg == S_CLR || state_reg == S_INIT))
        else $error("bin memory written outside an update or clear");

    // one item in work at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> !s_ready)
        else $error("second item accepted while one is in work");

    // increment writes back to the entry that was read
    a_rmw_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_UPD) |-> ($past(ram_raddr) == ram_waddr))
        else $error("read-modify-write address mismatch");

endmodule

[design/phs_bin_ram.sv]
module phs_bin_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

[design/phs_bin_map.sv]
module phs_bin_map (
    input  logic                        aclk,
    input  logic                        load,
    input  logic [phs_pkg::PC_W-1:0]    pc_value,
    input  logic [phs_pkg::PC_W-1:0]    base_pc,
    input  logic [phs_pkg::SCALE_W-1:0] scale,
    input  logic [phs_pkg::BINS_W-1:0]  bins_in_use,
    output phs_pkg::map_result_t        result
);
    import phs_pkg::*;

    logic [PC_W-1:0]   diff_reg;
    logic              ok_reg;
    logic [PROD_W-1:0] prod_reg;
    logic              ok2_reg;
    logic [PC_W-1:0]   bin_full;
    logic [PC_W-1:0]   bins_ext;
    logic [PC_W-1:0]   limit;

    // stage 1: offset from base, stage 2: scale multiply
    always_ff @(posedge aclk) begin
        if (load) begin
            diff_reg <= pc_value - base_pc;
            ok_reg   <= (pc_value >= base_pc) && (scale != '0);
        end
        prod_reg <= PROD_W'(diff_reg[PC_W-1:1]) * PROD_W'(scale);
        ok2_reg  <= ok_reg;
    end

    always_comb begin
        bin_full = prod_reg[PROD_W-1:16];
        bins_ext = PC_W'(bins_in_use);
        limit    = (bins_ext > PC_W'(NUM_BINS)) ? PC_W'(NUM_BINS) : bins_ext;
        result.hit   = ok2_reg && (bin_full < limit);
        result.addr  = bin_full[BIN_AW-1:0];
        result.index = bin_full[IDX_W-1:0];
    end

endmodule

[test/pc_sample_histogram_tb.sv]
module pc_sample_histogram_tb;
    import phs_pkg::*;

    localparam int CYCLE_LIMIT    = 3_000_000;
    localparam int LONG_HOLD      = 300;     // receiver hold-off that backs up the block
    localparam int DRAIN_CYCLES   = 40;      // quiet cycles after the last result
    localparam int RANDOM_ITEMS   = 1800;
    localparam int HAMMER_SAMPLES = 26;      // back-to-back hits on one bin at the end

    // request code that the block must treat as a no-op
    localparam logic [1:0]           REQ_UNKNOWN = 2'd3;
    // register index with nothing behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = CFG_IDX_W'(3);

    // Histogram predictor plus the queue of results still owed by the block.
    class hist_scoreboard;
        logic [COUNT_W-1:0] bin_tally [NUM_BINS];
        logic [PC_W-1:0]    base_pc;
        logic [SCALE_W-1:0] scale;
        logic [BINS_W-1:0]  bins_in_use;
        out_item_t          expected_q [$];
        int                 errors;

        function new();
            clear_tally();
            base_pc     = '0;
            scale       = '0;
            bins_in_use = BINS_RESET;
            errors      = 0;
        endfunction

        function void clear_tally();
            foreach (bin_tally[i]) bin_tally[i] = '0;
        endfunction

        function int unsigned bin_limit();
            return (bins_in_use > NUM_BINS) ? NUM_BINS : bins_in_use;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_BASE_PC:     base_pc = data;
                CFG_SCALE:       if (data[SCALE_W-1:0] <= SCALE_MAX) scale = data[SCALE_W-1:0];
                CFG_BINS_IN_USE: bins_in_use = data[BINS_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_input(in_item_t it);
            out_item_t          want;
            logic [PC_W-1:0]    delta;
            logic [PROD_W-1:0]  prod;
            logic [PC_W-1:0]    slot;
            logic [BIN_AW-1:0]  addr;
            want = '0;
            case (it.req_type)
                REQ_SAMPLE: begin
                    if (scale != 0 && it.pc_value >= base_pc) begin
                        delta = it.pc_value - base_pc;
                        prod  = PROD_W'(delta[PC_W-1:1]) * PROD_W'(scale);
                        slot  = prod[PROD_W-1:16];
                        if (slot < bin_limit()) begin
                            addr            = slot[BIN_AW-1:0];
                            bin_tally[addr] = COUNT_W'(bin_tally[addr] + 1);
                            want.counted    = 1'b1;
                            want.bin_index  = slot[IDX_W-1:0];
                            want.bin_count  = bin_tally[addr];
                        end
                    end
                end
                REQ_READ: begin
                    want.bin_index = it.read_bin;
                    if (it.read_bin < NUM_BINS) want.bin_count = bin_tally[it.read_bin];
                end
                REQ_CLEAR: clear_tally();
                default: ;
            endcase
            expected_q.push_back(want);
        endfunction

        task flag_mismatch(string what);
            errors++;
            $display("mismatch at %0t: %s", $time, what);
        endtask

        task check_result(out_item_t got);
            out_item_t want;
            if (expected_q.size() == 0) begin
                flag_mismatch($sformatf("result %h with none outstanding", got));
            end else begin
                want = expected_q.pop_front();
                if (got.counted !== want.counted)
                    flag_mismatch($sformatf("counted %b, want %b", got.counted, want.counted));
                if (got.bin_index !== want.bin_index)
                    flag_mismatch($sformatf("bin_index %0d, want %0d",
                                            got.bin_index, want.bin_index));
                if (got.bin_count !== want.bin_count)
                    flag_mismatch($sformatf("bin_count %0d, want %0d",
                                            got.bin_count, want.bin_count));
            end
        endtask
    endclass

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_data;

    hist_scoreboard phs_model = new();

    bit          idle_on       = 1'b0;  // random gaps/stalls allowed
    bit          long_hold_req = 1'b0;  // ask the receiver for one long hold-off
    int unsigned stall_left    = 0;
    int unsigned cycles        = 0;

    pc_sample_histogram i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("pc_sample_histogram_tb failed");
        $finish;
    end

    // Result side: check every accepted item, then pick next cycle's m_ready.
    // A long hold-off is counted down here so the sender keeps pushing meanwhile.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) phs_model.check_result(m_data);
        if (long_hold_req) begin
            long_hold_req = 1'b0;
            stall_left    = LONG_HOLD;
        end else if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 19);
        end
        if (stall_left != 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic in_item_t make_item(logic [1:0] kind, logic [PC_W-1:0] pc,
                                           logic [IDX_W-1:0] rbin);
        in_item_t it;
        it.req_type = kind;
        it.pc_value = pc;
        it.read_bin = rbin;
        return it;
    endfunction

    // Mostly samples aimed at the live bin range of the current setting, so the
    // counters actually build up; the rest is reads, clears, junk and misses.
    function automatic in_item_t random_item();
        in_item_t        it;
        int unsigned     pick;
        int unsigned     lim;
        longint unsigned span;
        longint unsigned headroom;
        longint unsigned offset;
        it   = make_item(REQ_SAMPLE, $urandom(), IDX_W'($urandom_range(0, NUM_BINS - 1)));
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
            it.req_type = REQ_CLEAR;
        end else if (pick < 3) begin
            it.req_type = REQ_UNKNOWN;
        end else if (pick < 20) begin
            it.req_type = REQ_READ;
            if ($urandom_range(0, 1) == 0) it.read_bin = IDX_W'($urandom_range(0, 15));
        end else if (pick < 28) begin
            // fully random PC, usually out of range
        end else if (pick < 33) begin
            if (phs_model.base_pc != 0) it.pc_value = $urandom_range(0, phs_model.base_pc - 1);
        end else begin
            lim = phs_model.bin_limit();
            if (lim == 0) lim = 1;
            if (phs_model.scale == 0) span = 64'd4096;
            else span = ((longint'(lim)) << 17) / phs_model.scale + 2;
            span     = span + span / 8;   // overshoot a little past the last bin
            headroom = 64'hFFFF_FFFF - phs_model.base_pc;
            if (span > headroom) span = headroom;
            offset = {$urandom(), $urandom()} % (span + 1);
            if ($urandom_range(0, 3) == 0) offset = offset % 64;
            it.pc_value = phs_model.base_pc + offset[PC_W-1:0];
        end
        return it;
    endfunction

    // Present one item and hold it until taken; an idle gap may come first.
    task automatic offer(in_item_t it);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        phs_model.note_input(it);
    endtask

    // Stop sending and let every outstanding result come back.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (phs_model.expected_q.size() != 0) @(posedge aclk);
    endtask

    // Leaves cfg_we high; caller drops it once the last write is done.
    task automatic drive_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        phs_model.write_reg(idx, data);
    endtask

    task automatic apply_config(logic [31:0] base, logic [31:0] scale_word,
                                logic [31:0] bins_word);
        drive_cfg(CFG_BASE_PC, base);
        drive_cfg(CFG_SCALE, scale_word);
        drive_cfg(CFG_BINS_IN_USE, bins_word);
        cfg_we <= 1'b0;
    endtask

    // New setting per phase, with the extremes and the ignored/clamped
    // encodings mixed in; upper write-data bits are sometimes junk.
    task automatic random_config();
        logic [31:0] base;
        logic [31:0] sc;
        logic [31:0] bw;
        case ($urandom_range(0, 4))
            0:       base = 32'd0;
            1:       base = 32'hFFFF_FFFF - $urandom_range(0, 4095);
            default: base = $urandom() >> $urandom_range(0, 31);
        endcase
        case ($urandom_range(0, 9))
            0:       sc = 32'd65536;
            1:       sc = 32'd1;
            2:       sc = 32'd0;
            3:       sc = $urandom_range(65537, 131071);
            default: sc = $urandom_range(1, 65536);
        endcase
        case ($urandom_range(0, 9))
            0:       bw = 32'd1;
            1:       bw = 32'd1024;
            2:       bw = 32'd0;
            3:       bw = $urandom_range(1025, 2047);
            4, 5:    bw = $urandom_range(1, 64);
            default: bw = $urandom_range(1, 1024);
        endcase
        if ($urandom_range(0, 3) == 0) sc = ($urandom() & 32'hFFFE_0000) | sc;
        if ($urandom_range(0, 3) == 0) bw = ($urandom() & 32'hFFFF_F800) | bw;
        apply_config(base, sc, bw);
    endtask

    initial begin
        int sent;
        int chunk;
        sent = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Registers are taken during the post-reset clearing pass; items wait
        // for s_ready, so nothing here counts cycles.
        apply_config(32'd0, 32'd65536, 32'd1024);

        // Directed: two bytes per bin, all 1024 bins live.
        offer(make_item(REQ_READ, 32'd0, 10'd0));            // fresh after reset
        offer(make_item(REQ_READ, 32'd0, 10'd1023));
        offer(make_item(REQ_SAMPLE, 32'd0, 10'd0));          // bin 0
        offer(make_item(REQ_SAMPLE, 32'd1, 10'd1023));       // bin 0 again
        offer(make_item(REQ_SAMPLE, 32'd2, 10'd0));          // bin 1
        offer(make_item(REQ_SAMPLE, 32'd2047, 10'd0));       // last bin
        offer(make_item(REQ_SAMPLE, 32'd2048, 10'd0));       // one past the last bin
        offer(make_item(REQ_SAMPLE, 32'hFFFF_FFFF, 10'd0));
        offer(make_item(REQ_READ, 32'hFFFF_FFFF, 10'd0));
        offer(make_item(REQ_READ, 32'd0, 10'd1023));
        offer(make_item(REQ_UNKNOWN, 32'hFFFF_FFFF, 10'h3FF));
        offer(make_item(REQ_CLEAR, 32'hFFFF_FFFF, 10'h3FF));
        offer(make_item(REQ_READ, 32'd0, 10'd0));            // zero after clear

        // Base near the top of the address space, finest scale, a single bin.
        wait_idle();
        apply_config(32'hFFFF_FFF0, 32'd1, 32'd1);
        offer(make_item(REQ_SAMPLE, 32'hFFFF_FFFF, 10'd0));
        offer(make_item(REQ_SAMPLE, 32'd0, 10'd0));          // below base
        offer(make_item(REQ_SAMPLE, 32'hFFFF_FFF0, 10'd0));  // exactly at base

        // Scale above its maximum must leave the old value in place.
        wait_idle();
        drive_cfg(CFG_SCALE, 32'h0001_FFFF);
        cfg_we <= 1'b0;
        offer(make_item(REQ_SAMPLE, 32'hFFFF_FFF1, 10'd0));

        // Scale zero turns counting off.
        wait_idle();
        drive_cfg(CFG_SCALE, 32'd0);
        cfg_we <= 1'b0;
        offer(make_item(REQ_SAMPLE, 32'hFFFF_FFF8, 10'd0));

        // No bins in use: nothing counts.
        wait_idle();
        apply_config(32'd0, 32'd65536, 32'd0);
        offer(make_item(REQ_SAMPLE, 32'd0, 10'd0));

        // Bin count past the table size clamps to the table; unused index is a no-op.
        wait_idle();
        drive_cfg(CFG_BINS_IN_USE, 32'd2047);
        drive_cfg(CFG_UNUSED, 32'hFFFF_FFFF);
        cfg_we <= 1'b0;
        offer(make_item(REQ_SAMPLE, 32'd2047, 10'd0));
        offer(make_item(REQ_READ, 32'd0, 10'd1023));

        // Random phases, each under its own setting; most phases with gaps
        // and stalls, some running flat out.
        while (sent < RANDOM_ITEMS) begin
            wait_idle();
            random_config();
            idle_on = ($urandom_range(0, 3) != 0);
            chunk   = $urandom_range(20, 120);
            for (int k = 0; k < chunk && sent < RANDOM_ITEMS; k++) begin
                if (sent == RANDOM_ITEMS / 2) long_hold_req = 1'b1;
                offer(random_item());
                sent++;
                // sender goes quiet until the block has answered everything
                if (sent == RANDOM_ITEMS / 3) wait_idle();
            end
        end

        // Last part, no idling: hammer one bin back to back.
        idle_on = 1'b0;
        wait_idle();
        apply_config(32'd0, 32'd65536, 32'd1024);
        offer(make_item(REQ_CLEAR, 32'd0, 10'd0));
        for (int k = 0; k < HAMMER_SAMPLES; k++) begin
            offer(make_item(REQ_SAMPLE, PC_W'($urandom_range(0, 1)),
                            IDX_W'($urandom_range(0, 1023))));
        end
        offer(make_item(REQ_READ, 32'd0, 10'd0));

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (phs_model.errors == 0 && phs_model.expected_q.size() == 0) begin
            $display("pc_sample_histogram_tb passed");
        end else begin
            $display("pc_sample_histogram_tb failed");
        end
        $finish;
    end

endmodule
